>>> src/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared widths, codes and word types for the glyph renderer modules.
// ----------------------------------------------------------------------------
package tcgr_pkg;

   // Font geometry limits.
   localparam int MAX_GLYPHS     = 512;
   localparam int MAX_GLYPH_ROWS = 32;
   localparam int GLYPH_WIDTH    = 8;
   localparam int GLYPH_SHIFT    = 3;

   // Field widths.
   localparam int CODE_W      = 16;
   localparam int COLOR_W     = 32;
   localparam int FONT_ADDR_W = 14;
   localparam int FONT_DEPTH  = 1 << FONT_ADDR_W;
   localparam int ROW_BITS_W  = 8;
   localparam int COL_W       = 10;
   localparam int ROW_W       = 9;
   localparam int HEIGHT_W    = 6;
   localparam int COUNT_W     = 10;
   localparam int GLYPH_SEL_W = 9;
   localparam int ROW_IDX_W   = 5;
   localparam int PIXEL_X_W   = 12;
   localparam int PIXEL_Y_W   = 13;
   localparam int CSR_INDEX_W = 3;

   // Shared multiplier: the glyph index and the cursor row ride in one operand.
   localparam int MCAND_W = GLYPH_SEL_W + FONT_ADDR_W;
   localparam int PROD_W  = MCAND_W + HEIGHT_W;

   // Character codes that only move the cursor.
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 16'd8;
   localparam logic [CODE_W-1:0] CODE_NEWLINE   = 16'd10;
   localparam logic [CODE_W-1:0] CODE_RETURN    = 16'd13;

   // Request and result kinds.
   localparam logic REQ_PUT       = 1'b0;
   localparam logic REQ_LOAD      = 1'b1;
   localparam logic RESULT_ROW    = 1'b0;
   localparam logic RESULT_SCROLL = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINES      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND = 3'd4;

   // Input word.
   typedef struct packed {
      logic                   req_type;
      logic [CODE_W-1:0]      char_code;
      logic [COLOR_W-1:0]     text_color;
      logic [FONT_ADDR_W-1:0] font_address;
      logic [ROW_BITS_W-1:0]  font_byte;
   } tcgr_req_type;

   // Result word.
   typedef struct packed {
      logic                  result_kind;
      logic [PIXEL_X_W-1:0]  pixel_x;
      logic [PIXEL_Y_W-1:0]  pixel_y;
      logic [ROW_BITS_W-1:0] row_bits;
      logic [COLOR_W-1:0]    fg_color;
      logic [COLOR_W-1:0]    bg_color;
      logic                  last;
   } tcgr_rsp_type;

   // Font memory write and read requests.
   typedef struct packed {
      logic                   en;
      logic [FONT_ADDR_W-1:0] addr;
      logic [ROW_BITS_W-1:0]  data;
   } tcgr_font_wr_type;

   typedef struct packed {
      logic                   en;
      logic [FONT_ADDR_W-1:0] addr;
   } tcgr_font_rd_type;

   // Shift-add multiplier command and status.
   typedef struct packed {
      logic                start;
      logic [MCAND_W-1:0]  mcand;
      logic [HEIGHT_W-1:0] mplier;
   } tcgr_mul_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [PROD_W-1:0] product;
   } tcgr_mul_stat_type;

endpackage

>>> src/tcgr_font_mem.sv
// ----------------------------------------------------------------------------
// Glyph font memory
// One write port and one registered read port over the glyph row bitmaps.
// ----------------------------------------------------------------------------
module tcgr_font_mem import tcgr_pkg::*; (
   input  logic                  clock,
   input  tcgr_font_wr_type      wr,
   input  tcgr_font_rd_type      rd,
   output logic [ROW_BITS_W-1:0] rd_data
);

   logic [ROW_BITS_W-1:0] mem [FONT_DEPTH];
   logic [ROW_BITS_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/tcgr_shift_add.sv
// ----------------------------------------------------------------------------
// Shift-add multiplier
// Multiplies by the glyph height one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tcgr_shift_add import tcgr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  tcgr_mul_cmd_type  cmd,
   output tcgr_mul_stat_type stat
);

   logic                busy_ff, busy_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [HEIGHT_W-1:0] mplier_ff, mplier_in;
   logic                done;

   // The product is complete once no multiplier bits remain.
   assign done = busy_ff && (mplier_ff == '0);

   // One add step a cycle.
   always_comb begin
      busy_in   = busy_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         acc_in    = '0;
         mcand_in  = PROD_W'(cmd.mcand);
         mplier_in = cmd.mplier;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign stat.busy    = busy_ff;
   assign stat.done    = done;
   assign stat.product = acc_ff;

endmodule

>>> src/text_console_glyph_renderer_unit.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Keeps a text cursor and a glyph font, and turns characters into glyph rows.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel takes one word per handshake: a font byte load or a
//   character to put. A load writes font memory in the accepting cycle and
//   gives no result. Backspace and carriage return give no result; a newline
//   gives a scroll word when it runs past the last line.
//   A printable character first goes through the shift-add multiplier
//   (up to six add steps; glyph base and pixel line in one product), and
//   the first font read issues as the product completes. Then comes one
//   glyph row word per cycle on rsp_ while rsp_ready allows, one font
//   memory read per row. A wrap past the last line adds a scroll word.
//   req_ready is high only between items. The final word of each item
//   carries last.
//   When rsp_ready is low the output register holds its word and the row
//   sequence pauses without losing a row.
//   The csr_ port is always ready; write it only while the block is idle.
//   Reset (synchronous) restores the register defaults and puts the cursor
//   at column 0, row 0. Font memory is not cleared and must be loaded
//   before glyphs are drawn.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_unit import tcgr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tcgr_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tcgr_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ROW,
      S_ADV,
      S_SCROLL
   } state_type;

   // Configuration registers.
   logic [COL_W-1:0]    cfg_cols_ff;
   logic [ROW_W-1:0]    cfg_lines_ff;
   logic [HEIGHT_W-1:0] cfg_height_ff;
   logic [COUNT_W-1:0]  cfg_count_ff;
   logic [COLOR_W-1:0]  cfg_bg_ff;

   // Sequencer registers.
   state_type              state_ff, state_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COLOR_W-1:0]     fg_ff, fg_in;
   logic [FONT_ADDR_W-1:0] addr_ff, addr_in;
   logic [PIXEL_Y_W-1:0]   y_ff, y_in;
   logic [ROW_IDX_W-1:0]   row_idx_ff, row_idx_in;
   logic                   force_ff, force_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tcgr_rsp_type           rsp_data_ff, rsp_data_in;

   // Derived values.
   logic [COL_W-1:0]       cols_sat;
   logic [ROW_W-1:0]       lines_sat;
   logic [HEIGHT_W-1:0]    h_sat;
   logic [COUNT_W-1:0]     count_sat;
   logic [COL_W-1:0]       col_inc;
   logic [ROW_W-1:0]       row_inc;
   logic [ROW_W-1:0]       row_after;
   logic                   line_scroll;
   logic                   glyph_scroll;
   logic                   slot_free;
   logic                   last_row;
   logic [GLYPH_SEL_W-1:0] glyph_sel;
   logic [FONT_ADDR_W-1:0] base_addr;
   logic [PIXEL_Y_W-1:0]   y_start;

   tcgr_font_wr_type      font_wr;
   tcgr_font_rd_type      font_rd;
   logic [ROW_BITS_W-1:0] font_data;
   tcgr_mul_cmd_type      mul_cmd;
   tcgr_mul_stat_type     mul_stat;

   // Configuration writes.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff   <= COL_W'(80);
         cfg_lines_ff  <= ROW_W'(25);
         cfg_height_ff <= HEIGHT_W'(16);
         cfg_count_ff  <= COUNT_W'(256);
         cfg_bg_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COLUMNS:    cfg_cols_ff   <= csr_wdata[COL_W-1:0];
            CSR_LINES:      cfg_lines_ff  <= csr_wdata[ROW_W-1:0];
            CSR_HEIGHT:     cfg_height_ff <= csr_wdata[HEIGHT_W-1:0];
            CSR_COUNT:      cfg_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_BACKGROUND: cfg_bg_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Registers clamped to their working ranges.
   assign cols_sat  = (cfg_cols_ff == '0) ? COL_W'(1) :
                      (cfg_cols_ff > COL_W'(512)) ? COL_W'(512) : cfg_cols_ff;
   assign lines_sat = (cfg_lines_ff == '0) ? ROW_W'(1) :
                      (cfg_lines_ff > ROW_W'(256)) ? ROW_W'(256) : cfg_lines_ff;
   assign h_sat     = (cfg_height_ff == '0) ? HEIGHT_W'(1) :
                      (cfg_height_ff > HEIGHT_W'(MAX_GLYPH_ROWS)) ?
                      HEIGHT_W'(MAX_GLYPH_ROWS) : cfg_height_ff;
   assign count_sat = (cfg_count_ff > COUNT_W'(MAX_GLYPHS)) ?
                      COUNT_W'(MAX_GLYPHS) : cfg_count_ff;

   // Cursor arithmetic for line advance and wrap.
   assign col_inc      = col_ff + COL_W'(1);
   assign row_inc      = row_ff + ROW_W'(1);
   assign line_scroll  = row_inc >= lines_sat;
   assign row_after    = line_scroll ? (lines_sat - ROW_W'(1)) : row_inc;
   assign glyph_scroll = (col_inc >= cols_sat) && line_scroll;

   // Codes past the font map to glyph 0.
   assign glyph_sel = (req_data.char_code < CODE_W'(count_sat)) ?
                      req_data.char_code[GLYPH_SEL_W-1:0] : '0;

   // Both products come out of one multiply: glyph base high, pixel line low.
   assign base_addr      = mul_stat.product[MCAND_W+HEIGHT_W-2 -: FONT_ADDR_W];
   assign y_start        = mul_stat.product[PIXEL_Y_W-1:0];

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_row  = ({1'b0, row_idx_ff} == (h_sat - HEIGHT_W'(1)));

   // Font loads go straight to memory.
   assign font_wr.en   = req_valid && req_ready && (req_data.req_type == REQ_LOAD);
   assign font_wr.addr = req_data.font_address;
   assign font_wr.data = req_data.font_byte;

   // Sequencer next state.
   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      fg_in          = fg_ff;
      addr_in        = addr_ff;
      y_in           = y_ff;
      row_idx_in     = row_idx_ff;
      force_in       = force_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      mul_cmd.start  = 1'b0;
      mul_cmd.mcand  = {glyph_sel, {(FONT_ADDR_W-ROW_W){1'b0}}, row_ff};
      mul_cmd.mplier = h_sat;
      font_rd.en     = 1'b0;
      font_rd.addr   = addr_ff + FONT_ADDR_W'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && (req_data.req_type == REQ_PUT)) begin
               case (req_data.char_code)
                  CODE_NEWLINE: begin
                     col_in   = '0;
                     force_in = 1'b1;
                     state_in = S_ADV;
                  end
                  CODE_BACKSPACE: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - COL_W'(1);
                     end
                     force_in = 1'b0;
                     state_in = S_ADV;
                  end
                  CODE_RETURN: begin
                     col_in = '0;
                  end
                  default: begin
                     fg_in         = req_data.text_color;
                     mul_cmd.start = 1'b1;
                     state_in      = S_MUL;
                  end
               endcase
            end
         end
         S_MUL: begin
            // Fetch the first glyph row as soon as the products are ready.
            if (mul_stat.done) begin
               addr_in      = base_addr;
               y_in         = y_start;
               row_idx_in   = '0;
               font_rd.en   = 1'b1;
               font_rd.addr = base_addr;
               state_in     = S_ROW;
            end
         end
         S_ROW: begin
            // One row word per cycle while the output slot is free; the next row is read as this one leaves.
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = RESULT_ROW;
               rsp_data_in.pixel_x     = PIXEL_X_W'({col_ff, {GLYPH_SHIFT{1'b0}}});
               rsp_data_in.pixel_y     = y_ff;
               rsp_data_in.row_bits    = font_data;
               rsp_data_in.fg_color    = fg_ff;
               rsp_data_in.bg_color    = cfg_bg_ff;
               rsp_data_in.last        = last_row && !glyph_scroll;
               if (last_row) begin
                  col_in   = col_inc;
                  force_in = 1'b0;
                  state_in = S_ADV;
               end else begin
                  font_rd.en = 1'b1;
                  addr_in    = addr_ff + FONT_ADDR_W'(1);
                  y_in       = y_ff + PIXEL_Y_W'(1);
                  row_idx_in = row_idx_ff + ROW_IDX_W'(1);
               end
            end
         end
         S_ADV: begin
            // Newline, or a column at or past the limit, starts the next line.
            if (force_ff || (col_ff >= cols_sat)) begin
               col_in   = '0;
               row_in   = row_after;
               state_in = line_scroll ? S_SCROLL : S_IDLE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCROLL: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = RESULT_SCROLL;
               rsp_data_in.pixel_x     = '0;
               rsp_data_in.pixel_y     = '0;
               rsp_data_in.row_bits    = '0;
               rsp_data_in.fg_color    = '0;
               rsp_data_in.bg_color    = cfg_bg_ff;
               rsp_data_in.last        = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fg_ff       <= fg_in;
      addr_ff     <= addr_in;
      y_ff        <= y_in;
      row_idx_ff  <= row_idx_in;
      force_ff    <= force_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Font memory.
   tcgr_font_mem u_font_mem (
      .clock   (clock),
      .wr      (font_wr),
      .rd      (font_rd),
      .rd_data (font_data)
   );

   // Shared multiplier.
   tcgr_shift_add u_shift_add (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .stat  (mul_stat)
   );

   // The row counter never runs past the glyph height.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW) |-> ({1'b0, row_idx_ff} < h_sat))
      else $error("glyph row counter beyond glyph height");

   // The multiplier is idle whenever a new word can be taken.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !mul_stat.busy)
      else $error("multiplier busy while idle");

   // A font load returns the block to idle at once.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.req_type == REQ_LOAD)) |=> req_ready)
      else $error("font load left the block busy");

   // A scroll word is always the final word of its item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.result_kind == RESULT_SCROLL)) |-> rsp_data.last)
      else $error("scroll word without last");

endmodule
